>>> hdl/integer_matrix_multiply_core_assert.svh
// assertion macros for the matrix multiply core
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define IMM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define IMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/imm_pkg.sv
// package for the matrix multiply core: constants and types
package imm_pkg;
  localparam int MAX_DIM_DEFAULT = 8;
  localparam int VAL_W = 16;
  localparam int ACC_W = 35;
  localparam int CFG_W = 4;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  // control handed down the cell chain with each term
  typedef struct packed {
    logic valid;
    logic first;
    logic fin;
    logic last;
    logic [2:0] row;
    logic [2:0] col;
  } term_ctl_t;
endpackage

>>> hdl/imm_ram.sv
// generic single-write, single-read ram with registered read
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/imm_cell.sv
// one cell of the multiply-accumulate chain
module imm_cell #(
  parameter int IN_W = 16,
  parameter int OUT_W = 35,
  parameter bit DO_MUL = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  imm_pkg::term_ctl_t     ctl_in,
  input  logic signed [IN_W-1:0] a_in,
  input  logic signed [IN_W-1:0] b_in,
  input  logic signed [OUT_W-1:0] sum_in,
  output imm_pkg::term_ctl_t     ctl_out,
  output logic signed [OUT_W-1:0] sum_out
);
  logic signed [OUT_W-1:0] acc_next;

  // multiply stage or accumulate stage
  always_comb begin
    if (DO_MUL) begin
      acc_next = OUT_W'(a_in * b_in);
    end else begin
      acc_next = ctl_in.first ? sum_in : (sum_out + sum_in);
    end
  end

  // pass control on, hold sum
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    if (ctl_in.valid) begin
      sum_out <= acc_next;
    end
  end
endmodule

>>> hdl/integer_matrix_multiply_core.sv
// Signed matrix product core. Loads of A or B elements give no result. A start
// walks each product element with a k counter, one term a cycle, through a
// chain of cells (ram read, multiply, accumulate); busy is high throughout.
// Results appear for one cycle under out_valid and cannot be stalled. A
// dimension mismatch gives one error result. Stores are undefined until
// written.
`include "integer_matrix_multiply_core_assert.svh"
module integer_matrix_multiply_core #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [2:0]  elem_row,
  input  logic [2:0]  elem_col,
  input  logic signed [15:0] elem_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_row,
  output logic [2:0]  out_col,
  output logic signed [34:0] product_value,
  output logic        dims_error,
  output logic        last
);
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW = imm_pkg::VAL_W;
  localparam int SW = imm_pkg::ACC_W;

  logic [3:0] rows_a, cols_a, rows_b, cols_b;
  imm_pkg::state_t state, state_next;
  logic [IW-1:0] ci, cj, ck, ra_m, ca_m, cb_m;
  logic last_k, last_j, last_i;
  logic in_acc, in_range;
  logic we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic signed [VW-1:0] rd_a, rd_b;
  imm_pkg::term_ctl_t ctl_issue, ctl_rd, ctl_mul, ctl_acc;
  logic signed [SW-1:0] prod, sum;
  logic err_pend;

  // saturate a dimension register to 1..MAX_DIM, minus one
  function automatic logic [IW-1:0] dim_m1(input logic [3:0] r);
    logic [3:0] e;
    e = (r == 4'd0) ? 4'd1 : ((32'(r) > MAX_DIM) ? 4'(MAX_DIM) : r);
    return IW'(e - 4'd1);
  endfunction

  assign ra_m = dim_m1(rows_a);
  assign ca_m = dim_m1(cols_a);
  assign cb_m = dim_m1(cols_b);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= 4'd1; cols_a <= 4'd1; rows_b <= 4'd1; cols_b <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imm_pkg::REG_ROWS_A: rows_a <= cfg_data;
        imm_pkg::REG_COLS_A: cols_a <= cfg_data;
        imm_pkg::REG_ROWS_B: rows_b <= cfg_data;
        imm_pkg::REG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // load decode
  assign in_acc = start && !busy;
  assign in_range = (32'(elem_row) < MAX_DIM) && (32'(elem_col) < MAX_DIM);
  assign we_a = in_acc && in_range && (kind == imm_pkg::KIND_LOAD_A);
  assign we_b = in_acc && in_range && (kind == imm_pkg::KIND_LOAD_B);
  assign waddr = AW'(32'(elem_row) * MAX_DIM + 32'(elem_col));
  assign raddr_a = AW'(32'(ci) * MAX_DIM + 32'(ck));
  assign raddr_b = AW'(32'(ck) * MAX_DIM + 32'(cj));

  imm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(elem_value),
    .raddr(raddr_a), .rdata(rd_a));
  imm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(elem_value),
    .raddr(raddr_b), .rdata(rd_b));

  assign last_k = (ck == ca_m);
  assign last_j = (cj == cb_m);
  assign last_i = (ci == ra_m);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      imm_pkg::ST_IDLE: begin
        if (in_acc && kind == imm_pkg::KIND_START) begin
          state_next = (cols_a == rows_b || dim_m1(cols_a) == dim_m1(rows_b))
                       ? imm_pkg::ST_RUN : imm_pkg::ST_IDLE;
        end
      end
      imm_pkg::ST_RUN: if (last_k && last_j && last_i) state_next = imm_pkg::ST_DRAIN;
      imm_pkg::ST_DRAIN: if (ctl_acc.valid && ctl_acc.last) state_next = imm_pkg::ST_IDLE;
      default: state_next = imm_pkg::ST_IDLE;
    endcase
  end

  // issue control for the chain
  always_comb begin
    ctl_issue = '0;
    if (state == imm_pkg::ST_RUN) begin
      ctl_issue.valid = 1'b1;
      ctl_issue.first = (ck == '0);
      ctl_issue.fin = last_k;
      ctl_issue.last = last_k && last_j && last_i;
      ctl_issue.row = 3'(ci);
      ctl_issue.col = 3'(cj);
    end
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imm_pkg::ST_IDLE;
      ci <= '0; cj <= '0; ck <= '0;
      err_pend <= 1'b0;
      ctl_rd <= '0;
    end else begin
      state <= state_next;
      ctl_rd <= ctl_issue;
      err_pend <= in_acc && kind == imm_pkg::KIND_START &&
                  dim_m1(cols_a) != dim_m1(rows_b);
      if (state == imm_pkg::ST_RUN) begin
        if (!last_k) begin
          ck <= ck + 1'b1;
        end else begin
          ck <= '0;
          if (!last_j) begin
            cj <= cj + 1'b1;
          end else begin
            cj <= '0;
            ci <= last_i ? '0 : ci + 1'b1;
          end
        end
      end
    end
  end

  imm_cell #(.IN_W(VW), .OUT_W(SW), .DO_MUL(1'b1)) u_mul (
    .clk(clk), .rst(rst), .ctl_in(ctl_rd), .a_in(rd_a), .b_in(rd_b),
    .sum_in('0), .ctl_out(ctl_mul), .sum_out(prod));
  imm_cell #(.IN_W(VW), .OUT_W(SW), .DO_MUL(1'b0)) u_acc (
    .clk(clk), .rst(rst), .ctl_in(ctl_mul), .a_in('0), .b_in('0),
    .sum_in(prod), .ctl_out(ctl_acc), .sum_out(sum));

  // result outputs
  assign busy = (state != imm_pkg::ST_IDLE) || err_pend;
  always_comb begin
    out_valid = err_pend || (ctl_acc.valid && ctl_acc.fin);
    dims_error = err_pend;
    last = err_pend || ctl_acc.last;
    out_row = err_pend ? 3'd0 : ctl_acc.row;
    out_col = err_pend ? 3'd0 : ctl_acc.col;
    product_value = err_pend ? '0 : sum;
  end

  `IMM_ASSERT_IMPLY(a_err_alone, err_pend, !ctl_acc.valid && state == imm_pkg::ST_IDLE)
  `IMM_ASSERT_IMPLY(a_last_ends, out_valid && last && !dims_error, state == imm_pkg::ST_DRAIN)
  `IMM_ASSERT_NEXT(a_err_once, err_pend, !err_pend)
endmodule
